FILE: rtl/qets_pkg.sv
package qets_pkg;

    localparam int INDEX_BITS       = 16;
    localparam int SMOOTH_WINDOW    = 10;
    localparam int SMOOTH_THRESHOLD = 5;
    localparam int HIST_DEPTH       = 2 * SMOOTH_WINDOW + 1;
    localparam int CNT_BITS         = $clog2(SMOOTH_WINDOW + 1);

    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 16;
    localparam int SLOPE_BITS  = 2;
    localparam int RANGE_BITS  = 16;
    localparam int TRIG_BITS   = 16;
    localparam int CMP_BITS    = (INDEX_BITS > RANGE_BITS) ? INDEX_BITS : RANGE_BITS;

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_SEL_BITS  = 3;

    localparam logic [REG_SEL_BITS-1:0] REG_TRIGGER_LEVEL = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_SLOPE_MODE    = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_SMOOTH_ENABLE = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_SEARCH_START  = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_SEARCH_END    = 3'd4;

    localparam logic [SLOPE_BITS-1:0] SLOPE_RISING  = 2'd0;
    localparam logic [SLOPE_BITS-1:0] SLOPE_FALLING = 2'd1;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] trigger_level;
        logic [SLOPE_BITS-1:0] slope_mode;
        logic                  smooth_enable;
        logic [RANGE_BITS-1:0] search_start;
        logic [RANGE_BITS-1:0] search_end;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [TRIG_BITS-1:0] index;
    } result_t;

endpackage

FILE: rtl/qets_apb_regs.sv
module qets_apb_regs import qets_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [REG_SEL_BITS-1:0] sel;
    logic                    wr_en;

    assign pready = 1'b1;
    assign sel    = paddr[APB_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (sel)
                REG_TRIGGER_LEVEL: cfg_next.trigger_level = pwdata[LEVEL_BITS-1:0];
                REG_SLOPE_MODE:    cfg_next.slope_mode    = pwdata[SLOPE_BITS-1:0];
                REG_SMOOTH_ENABLE: cfg_next.smooth_enable = pwdata[0];
                REG_SEARCH_START:  cfg_next.search_start  = pwdata[RANGE_BITS-1:0];
                REG_SEARCH_END:    cfg_next.search_end    = pwdata[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_TRIGGER_LEVEL: prdata = APB_DATA_BITS'(cfg_reg.trigger_level);
            REG_SLOPE_MODE:    prdata = APB_DATA_BITS'(cfg_reg.slope_mode);
            REG_SMOOTH_ENABLE: prdata = APB_DATA_BITS'(cfg_reg.smooth_enable);
            REG_SEARCH_START:  prdata = APB_DATA_BITS'(cfg_reg.search_start);
            REG_SEARCH_END:    prdata = APB_DATA_BITS'(cfg_reg.search_end);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/qets_frame_core.sv
module qets_frame_core import qets_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    input  cfg_t                   cfg,
    output result_t                res
);

    logic [HIST_DEPTH-1:0] hist_reg;
    logic [HIST_DEPTH-1:0] hist_next;
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_next;
    logic                  done_reg;
    logic                  done_next;

    logic                  store;
    logic                  beyond;
    logic [HIST_DEPTH-1:0] hist_new;
    logic [INDEX_BITS-1:0] count_new;
    logic [INDEX_BITS-1:0] n_eff;
    logic [SMOOTH_WINDOW:0] lane_ok;
    logic                  main_found;
    logic                  end_found;
    logic [INDEX_BITS-1:0] end_idx;
    logic [INDEX_BITS-1:0] main_idx;
    logic [INDEX_BITS-1:0] found_idx;
    logic                  found;

    // judge the candidate d samples before the newest one
    function automatic logic judge(input logic [HIST_DEPTH-1:0] h,
                                   input logic [INDEX_BITS-1:0] n,
                                   input int d,
                                   input cfg_t c_cfg);
        logic [INDEX_BITS-1:0] c;
        logic [CNT_BITS-1:0]   pre_cnt;
        logic [CNT_BITS-1:0]   after;
        int                    w;
        int                    t;
        logic                  ok;
        w       = c_cfg.smooth_enable ? SMOOTH_WINDOW : 1;
        t       = c_cfg.smooth_enable ? SMOOTH_THRESHOLD : 0;
        c       = n - INDEX_BITS'(d);
        pre_cnt = '0;
        after   = '0;
        ok = (INDEX_BITS'(d) <= n)
             && (c_cfg.slope_mode == SLOPE_RISING || c_cfg.slope_mode == SLOPE_FALLING)
             && (CMP_BITS'(c) > CMP_BITS'(c_cfg.search_start))
             && (CMP_BITS'(c) < CMP_BITS'(c_cfg.search_end))
             && h[d] && !h[d+1];
        for (int j = 1; j <= SMOOTH_WINDOW; j++) begin
            if (j <= w && c > INDEX_BITS'(j) && !h[d+j]) begin
                pre_cnt = pre_cnt + CNT_BITS'(1);
            end
            if (j <= w && j <= d && h[(d >= j) ? d - j : 0]) begin
                after = after + CNT_BITS'(1);
            end
        end
        return ok && (pre_cnt > CNT_BITS'(t)) && (after > CNT_BITS'(t));
    endfunction

    always_comb begin
        store = (count_reg != COUNT_MAX);
        if (cfg.slope_mode == SLOPE_RISING) begin
            beyond = $signed(sample) >= $signed(cfg.trigger_level);
        end else begin
            beyond = $signed(sample) <= $signed(cfg.trigger_level);
        end
        hist_new  = store ? {hist_reg[HIST_DEPTH-2:0], beyond} : hist_reg;
        count_new = store ? count_reg + INDEX_BITS'(1) : count_reg;
        n_eff     = count_new - INDEX_BITS'(1);

        for (int d = 0; d <= SMOOTH_WINDOW; d++) begin
            lane_ok[d] = judge(hist_new, n_eff, d, cfg);
        end

        // judged once its after window is full
        if (cfg.smooth_enable) begin
            main_found = store && !done_reg && lane_ok[SMOOTH_WINDOW];
            main_idx   = n_eff - INDEX_BITS'(SMOOTH_WINDOW);
        end else begin
            main_found = store && !done_reg && lane_ok[1];
            main_idx   = n_eff - INDEX_BITS'(1);
        end

        // frame end: pending candidates, earliest wins
        end_found = 1'b0;
        end_idx   = '0;
        for (int d = 0; d < SMOOTH_WINDOW; d++) begin
            if ((cfg.smooth_enable || d == 0) && lane_ok[d]) begin
                end_found = 1'b1;
                end_idx   = n_eff - INDEX_BITS'(d);
            end
        end

        found     = main_found || (last && !done_reg && end_found);
        found_idx = main_found ? main_idx : end_idx;

        res.valid = !done_reg && (found || last);
        res.found = found;
        res.index = found ? TRIG_BITS'(found_idx) : '0;

        hist_next  = hist_reg;
        count_next = count_reg;
        done_next  = done_reg;
        if (step) begin
            if (last) begin
                hist_next  = '0;
                count_next = '0;
                done_next  = 1'b0;
            end else begin
                hist_next  = hist_new;
                count_next = count_new;
                done_next  = done_reg || res.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            hist_reg  <= hist_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> count_reg == '0 && hist_reg == '0 && !done_reg)
        else $error("frame state not cleared after last item");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.valid && res.found |->
            CMP_BITS'(found_idx) > CMP_BITS'(cfg.search_start)
            && CMP_BITS'(found_idx) < CMP_BITS'(cfg.search_end))
        else $error("trigger index outside search range");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && count_reg == COUNT_MAX |=> count_reg == COUNT_MAX)
        else $error("sample counter moved past saturation");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.valid && !last |=> done_reg)
        else $error("frame can give a second result");

endmodule

FILE: rtl/qualified_edge_trigger_search.sv
// Edge trigger search over a stream of sample frames. Each accepted item is one
// sample; the first item of a frame has index 0 and the frame ends with tlast.
// At most one result item comes per frame: the first qualified edge in the
// search range as soon as its after window is complete or the frame ends
// (tuser high, index in tdata), or a not-found result (tuser low, tdata zero)
// with the frame's last sample. One item is accepted every clock cycle unless
// the output stalls; a sample passes an input register and a result register,
// and a result waits in the result register until it is taken. The per-sample
// work is one pass of the history shift register and the eleven parallel window
// checks between those two registers. Configuration is to be written over the
// APB port only while the stream is idle; the block does not enforce this.
module qualified_edge_trigger_search import qets_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [SAMPLE_BITS-1:0]   s_tdata,   // sample_value
    input  logic                     s_tlast,   // frame_last
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [TRIG_BITS-1:0]     m_tdata,   // trigger_index
    output logic [0:0]               m_tuser,   // trigger_found
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t                   cfg;
    result_t                res;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic [TRIG_BITS-1:0]   out_index_reg;
    logic                   advance;

    qets_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qets_frame_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sample  (sample_reg),
        .last    (last_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = out_found_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
            last_reg   <= s_tlast;
        end
        if (advance && res.valid) begin
            out_found_reg <= res.found;
            out_index_reg <= res.index;
        end
    end

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending item dropped while output stalled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result overwritten before it was taken");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("waiting result item changed");

endmodule

FILE: verif/trigger_search_checker.sv
`timescale 1ns / 1ps

module trigger_search_checker import qets_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [SAMPLE_BITS-1:0]   s_tdata,   // sample_value
    input  logic                     s_tlast,   // frame_last
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [TRIG_BITS-1:0]     m_tdata,   // trigger_index
    input  logic [0:0]               m_tuser,   // trigger_found
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       errors,
    output int                       results_due
);

    typedef struct packed {
        logic                 found;
        logic [TRIG_BITS-1:0] index;
    } trigger_t;

    cfg_t                  regs;
    logic [HIST_DEPTH-1:0] beyond_hist;
    logic [INDEX_BITS-1:0] sample_cnt;
    logic                  frame_closed;
    trigger_t              trigger_q[$];
    trigger_t              oldest;

    function automatic int window_len();
        return regs.smooth_enable ? SMOOTH_WINDOW : 1;
    endfunction

    function automatic bit hist_at(int d);
        return (d < HIST_DEPTH) ? beyond_hist[d] : 1'b0;
    endfunction

    // candidate sits d samples behind the newest stored index n
    function automatic bit edge_confirmed(int n, int d);
        int win, thr, c, below_cnt, above_cnt;
        win = window_len();
        thr = regs.smooth_enable ? SMOOTH_THRESHOLD : 0;
        below_cnt = 0;
        above_cnt = 0;
        if (d > n || regs.slope_mode > SLOPE_FALLING)
            return 1'b0;
        c = n - d;
        if (c <= int'(regs.search_start) || c >= int'(regs.search_end))
            return 1'b0;
        if (!hist_at(d) || hist_at(d + 1))
            return 1'b0;
        // index zero never counts toward the window before the edge
        for (int j = 1; j <= win && c >= j + 1; j++)
            if (!hist_at(d + j))
                below_cnt++;
        for (int j = 1; j <= win && j <= d; j++)
            if (hist_at(d - j))
                above_cnt++;
        return below_cnt > thr && above_cnt > thr;
    endfunction

    function automatic void take_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
        logic is_beyond;
        bit   hit;
        int   idx, n, win;
        hit = 1'b0;
        idx = 0;
        win = window_len();
        if (sample_cnt != COUNT_MAX) begin
            n = int'(sample_cnt);
            if (regs.slope_mode == SLOPE_RISING)
                is_beyond = $signed(raw) >= $signed(regs.trigger_level);
            else
                is_beyond = $signed(raw) <= $signed(regs.trigger_level);
            beyond_hist = {beyond_hist[HIST_DEPTH-2:0], is_beyond};
            sample_cnt  = sample_cnt + 1'b1;
            if (!frame_closed && n >= win && edge_confirmed(n, win)) begin
                hit = 1'b1;
                idx = n - win;
            end
        end
        // short frame end: judge waiting candidates, earliest first
        if (last && !frame_closed && !hit && sample_cnt != 0) begin
            n = int'(sample_cnt) - 1;
            for (int d = win - 1; d >= 0 && !hit; d--)
                if (edge_confirmed(n, d)) begin
                    hit = 1'b1;
                    idx = n - d;
                end
        end
        if (!frame_closed && (hit || last)) begin
            trigger_q.push_back('{found: hit, index: hit ? TRIG_BITS'(idx) : '0});
            frame_closed = 1'b1;
        end
        if (last) begin
            beyond_hist  = '0;
            sample_cnt   = '0;
            frame_closed = 1'b0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs         = '0;
            beyond_hist  = '0;
            sample_cnt   = '0;
            frame_closed = 1'b0;
            trigger_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (trigger_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual found=%0d index=%0d",
                             $time, m_tuser[0], m_tdata);
                end else begin
                    oldest = trigger_q.pop_front();
                    if (m_tuser[0] !== oldest.found) begin
                        errors++;
                        $display("%0t: trigger_found expected %0d actual %0d",
                                 $time, oldest.found, m_tuser[0]);
                    end
                    if (m_tdata !== oldest.index) begin
                        errors++;
                        $display("%0t: trigger_index expected %0d actual %0d",
                                 $time, oldest.index, m_tdata);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_TRIGGER_LEVEL: regs.trigger_level = pwdata[LEVEL_BITS-1:0];
                    REG_SLOPE_MODE:    regs.slope_mode    = pwdata[SLOPE_BITS-1:0];
                    REG_SMOOTH_ENABLE: regs.smooth_enable = pwdata[0];
                    REG_SEARCH_START:  regs.search_start  = pwdata[RANGE_BITS-1:0];
                    REG_SEARCH_END:    regs.search_end    = pwdata[RANGE_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tlast);
        end
        results_due = trigger_q.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import qets_pkg::*;

    localparam logic [SLOPE_BITS-1:0] SLOPE_OFF    = 2'd2;
    localparam logic [SLOPE_BITS-1:0] SLOPE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [SAMPLE_BITS-1:0]   s_tdata;   // sample_value
    logic                     s_tlast;   // frame_last
    logic                     m_tvalid;
    logic                     m_tready;
    logic [TRIG_BITS-1:0]     m_tdata;   // trigger_index
    logic [0:0]               m_tuser;   // trigger_found
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int errors;
    int results_due;
    int stall_cycles;
    int cur_level;
    logic [SLOPE_BITS-1:0] cur_slope;
    logic [RANGE_BITS-1:0] lo_idx;
    bit quiet;
    bit hold_off;

    qualified_edge_trigger_search i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    trigger_search_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .errors      (errors),
        .results_due (results_due)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("qualified_edge_trigger_search: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 20);
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(bit want_beyond);
        int lo, hi, span, off;
        bit above;
        if ($urandom_range(0, 9) == 0)
            return SAMPLE_BITS'($urandom);
        above = (want_beyond == (cur_slope == SLOPE_RISING));
        lo = above ? ((cur_slope == SLOPE_RISING) ? cur_level : cur_level + 1) : -32768;
        hi = above ? 32767 : ((cur_slope == SLOPE_RISING) ? cur_level - 1 : cur_level);
        if (lo > hi)
            return SAMPLE_BITS'(cur_level);
        span = hi - lo;
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span)
                                          : $urandom_range(0, (span < 200) ? span : 200);
        return above ? SAMPLE_BITS'(lo + off) : SAMPLE_BITS'(hi - off);
    endfunction

    task automatic push_item(logic [SAMPLE_BITS-1:0] value, logic last);
        if (!quiet && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic reg_write(logic [REG_SEL_BITS-1:0] sel, logic [RANGE_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {{(APB_DATA_BITS - RANGE_BITS){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(logic [LEVEL_BITS-1:0] level, logic [SLOPE_BITS-1:0] slope,
                              logic smooth, logic [RANGE_BITS-1:0] start_idx,
                              logic [RANGE_BITS-1:0] end_idx);
        wait_idle();
        reg_write(REG_TRIGGER_LEVEL, level);
        reg_write(REG_SLOPE_MODE, RANGE_BITS'(slope));
        reg_write(REG_SMOOTH_ENABLE, RANGE_BITS'(smooth));
        reg_write(REG_SEARCH_START, start_idx);
        reg_write(REG_SEARCH_END, end_idx);
        cur_level = int'($signed(level));
        cur_slope = slope;
    endtask

    // runs of beyond / not beyond samples with an occasional single glitch
    task automatic send_frame(int len);
        bit run_hi, want;
        run_hi = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0)
                run_hi = !run_hi;
            want = run_hi ^ ($urandom_range(0, 19) == 0);
            push_item(pick_sample(want), k == len - 1);
        end
    endtask

    task automatic send_frames(int n_items, int min_len, int max_len);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(min_len, max_len);
            send_frame(len);
            sent += len;
        end
    endtask

    task automatic run_phase(logic [LEVEL_BITS-1:0] level, logic [SLOPE_BITS-1:0] slope,
                             logic smooth, logic [RANGE_BITS-1:0] start_idx,
                             logic [RANGE_BITS-1:0] end_idx, int n_items);
        set_config(level, slope, smooth, start_idx, end_idx);
        send_frames(n_items, 1, 60);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        hold_off = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // edge right after index zero cannot qualify
        set_config(16'd0, SLOPE_RISING, 1'b0, 16'd0, 16'd100);
        push_item(16'h8000, 1'b0);
        push_item(16'h7fff, 1'b0);
        push_item(16'h7fff, 1'b0);
        push_item(16'h8000, 1'b1);
        // edge found, rest of the frame ignored
        push_item(16'hffff, 1'b0);
        push_item(16'hffff, 1'b0);
        push_item(16'h0000, 1'b0);
        push_item(16'h0000, 1'b0);
        push_item(16'h0007, 1'b0);
        push_item(16'hfffd, 1'b1);
        // smoothed edge judged on a cut after window at frame end
        set_config(16'd0, SLOPE_RISING, 1'b1, 16'd0, 16'd100);
        repeat (8) push_item(-16'sd100, 1'b0);
        repeat (6) push_item(16'd100, 1'b0);
        push_item(16'd100, 1'b1);

        run_phase(16'd0, SLOPE_RISING, 1'b0, 16'd0, 16'hffff, 70);
        quiet = 1'b1;
        run_phase(16'($urandom_range(0, 2000) - 1000), SLOPE_FALLING, 1'b1,
                  16'd0, 16'hffff, 70);
        quiet = 1'b0;
        lo_idx = 16'($urandom_range(0, 15));
        run_phase(16'($urandom_range(0, 2000) - 1000), SLOPE_RISING, 1'b1,
                  lo_idx, lo_idx + 16'($urandom_range(5, 50)), 70);
        run_phase(16'h7fff, SLOPE_FALLING, 1'b0, 16'd0, 16'hffff, 70);
        run_phase(16'h8000, SLOPE_RISING, 1'b1, 16'd0, 16'hffff, 70);
        run_phase(16'h7fff, SLOPE_RISING, 1'b0, 16'd0, 16'hffff, 70);
        run_phase(16'd0, SLOPE_OFF, 1'b0, 16'd0, 16'hffff, 70);
        run_phase(16'd0, SLOPE_UNUSED, 1'b1, 16'd0, 16'hffff, 70);
        run_phase(16'd0, SLOPE_RISING, 1'b1, 16'hffff, 16'd0, 70);
        run_phase(16'd0, SLOPE_FALLING, 1'b0, 16'd40, 16'd20, 70);

        // results back up while short frames keep coming
        set_config(16'd0, SLOPE_RISING, 1'b0, 16'd0, 16'hffff);
        hold_off = 1'b1;
        send_frames(100, 1, 3);

        for (int p = 0; p < 4; p++) begin
            lo_idx = 16'($urandom_range(0, 12));
            run_phase(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 2000) - 1000),
                      ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                                 : 2'($urandom_range(2, 3)),
                      1'($urandom_range(0, 1)),
                      lo_idx,
                      ($urandom_range(0, 4) == 0) ? 16'hffff
                                                  : lo_idx + 16'($urandom_range(0, 60)),
                      70);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && results_due == 0)
            $display("qualified_edge_trigger_search: match");
        else
            $display("qualified_edge_trigger_search: mismatch");
        $finish;
    end

endmodule
